// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL datapath (gdfo_dpath).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds on every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant violated");

// Check that a condition implies another on the same clock edge.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");

`endif

// ===== rtl/gdfo_pkg.sv =====
`default_nettype none

package gdfo_pkg;

    localparam int NODE_W   = 5;
    localparam int NODE_LIM = 2 ** NODE_W;
    localparam int CNT_W    = 6;

    localparam logic [CNT_W-1:0] NODE_COUNT_RST = 6'd32;

    localparam logic CMD_ADD_EDGE = 1'b0;
    localparam logic CMD_SEARCH   = 1'b1;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic edge_wr;
        logic start;
        logic row_load;
        logic emit_root;
        logic emit_child;
        logic pop;
        logic next_root;
    } t_ctl_cmd;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic src_ok;
        logic found;
        logic depth_one;
        logic unvisited;
        logic out_free;
    } t_ctl_stat;

endpackage

`default_nettype wire

// ===== rtl/gdfo_ctrl.sv =====
`default_nettype none

module gdfo_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_cmd,
    output logic                 o_in_stall,
    input  gdfo_pkg::t_ctl_stat  i_stat,
    output gdfo_pkg::t_ctl_cmd   o_cmd
);
    import gdfo_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ROOT = 5'b00010,
        S_READ = 5'b00100,
        S_SCAN = 5'b01000,
        S_NEXT = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_cmd == CMD_ADD_EDGE) begin
                        o_cmd.edge_wr = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        // drop searches whose source is not in use
                        if (i_stat.src_ok) begin
                            n_state = S_ROOT;
                        end
                    end
                end
            end
            S_ROOT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_root = 1'b1;
                    n_state         = S_READ;
                end
            end
            S_READ: begin
                o_cmd.row_load = 1'b1;
                n_state        = S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.found) begin
                    // hold until the output register can take the request
                    if (i_stat.out_free) begin
                        o_cmd.emit_child = 1'b1;
                        n_state          = S_READ;
                    end
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = i_stat.depth_one ? S_NEXT : S_READ;
                end
            end
            S_NEXT: begin
                if (i_stat.unvisited) begin
                    o_cmd.next_root = 1'b1;
                    n_state         = S_ROOT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/gdfo_dpath.sv =====
`default_nettype none
`include "assert_macros.svh"

module gdfo_dpath #(
    parameter int MAX_NODES = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [gdfo_pkg::CNT_W-1:0]  i_cfg_data,
    input  logic [gdfo_pkg::NODE_W-1:0] i_node_a,
    input  logic [gdfo_pkg::NODE_W-1:0] i_node_b,
    input  gdfo_pkg::t_ctl_cmd          i_cmd,
    output gdfo_pkg::t_ctl_stat         o_stat,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [gdfo_pkg::NODE_W-1:0] o_visited_node,
    output logic [gdfo_pkg::NODE_W-1:0] o_parent_node,
    output logic                        o_last
);
    import gdfo_pkg::*;

    localparam int LIM = (MAX_NODES < NODE_LIM) ? MAX_NODES : NODE_LIM;
    localparam int IW  = $clog2(LIM);
    localparam int DW  = $clog2(LIM + 1);
    localparam logic [CNT_W-1:0] LIM_C = CNT_W'(LIM);

    logic [CNT_W-1:0]  r_node_count;
    logic [LIM-1:0]    r_adj [LIM];
    logic [LIM-1:0]    r_visited;
    logic [NODE_W-1:0] r_stack [LIM];
    logic [DW-1:0]     r_depth;
    logic [DW-1:0]     r_cnt;
    logic [CNT_W-1:0]  r_n;
    logic [NODE_W-1:0] r_src;
    logic [NODE_W-1:0] r_root;
    logic [NODE_W-1:0] r_root_par;
    logic [LIM-1:0]    r_row;
    logic [NODE_W-1:0] r_top;
    logic              r_out_valid;
    logic [NODE_W-1:0] r_out_node;
    logic [NODE_W-1:0] r_out_par;
    logic              r_out_last;

    logic [CNT_W-1:0]  n_use;
    logic              a_ok;
    logic              b_ok;
    logic [IW-1:0]     a_idx;
    logic [IW-1:0]     b_idx;
    logic [LIM-1:0]    inuse;
    logic [LIM-1:0]    cand;
    logic [LIM-1:0]    unv;
    logic              found;
    logic [NODE_W-1:0] found_idx;
    logic              any_unv;
    logic [NODE_W-1:0] next_idx;
    logic [DW-1:0]     depth_m1;
    logic [DW-1:0]     depth_m2;
    logic [IW-1:0]     top_idx;
    logic              emit;
    logic [NODE_W-1:0] emit_node;
    logic [NODE_W-1:0] emit_par;
    logic              emit_last;
    logic              out_free;

    assign n_use = (r_node_count > LIM_C) ? LIM_C : r_node_count;
    assign a_ok  = CNT_W'(i_node_a) < LIM_C;
    assign b_ok  = CNT_W'(i_node_b) < LIM_C;
    assign a_idx = i_node_a[IW-1:0];
    assign b_idx = i_node_b[IW-1:0];

    always_comb begin
        for (int i = 0; i < LIM; i++) begin
            inuse[i] = CNT_W'(i) < r_n;
        end
    end

    assign cand = r_row & ~r_visited & inuse;
    assign unv  = ~r_visited & inuse;

    // lowest set bit wins
    always_comb begin
        found     = 1'b0;
        found_idx = '0;
        any_unv   = 1'b0;
        next_idx  = '0;
        for (int i = LIM - 1; i >= 0; i--) begin
            if (cand[i]) begin
                found     = 1'b1;
                found_idx = NODE_W'(i);
            end
            if (unv[i]) begin
                any_unv  = 1'b1;
                next_idx = NODE_W'(i);
            end
        end
    end

    assign depth_m1 = r_depth - DW'(1);
    assign depth_m2 = r_depth - DW'(2);
    assign top_idx  = r_top[IW-1:0];

    assign emit      = i_cmd.emit_root || i_cmd.emit_child;
    assign emit_node = i_cmd.emit_root ? r_root : found_idx;
    assign emit_par  = i_cmd.emit_root ? r_root_par : r_top;
    assign emit_last = (CNT_W'(r_cnt) + CNT_W'(1)) == r_n;
    assign out_free  = !r_out_valid || !i_out_stall;

    assign o_stat.src_ok    = CNT_W'(i_node_a) < n_use;
    assign o_stat.found     = found && (r_depth < DW'(LIM));
    assign o_stat.depth_one = r_depth == DW'(1);
    assign o_stat.unvisited = any_unv;
    assign o_stat.out_free  = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RST;
        end else if (i_cfg_we) begin
            r_node_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < LIM; r++) begin
                r_adj[r] <= '0;
            end
        end else if (i_cmd.edge_wr && a_ok && b_ok) begin
            r_adj[a_idx][b_idx] <= 1'b1;
            r_adj[b_idx][a_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_visited <= '0;
            r_depth   <= '0;
            r_cnt     <= '0;
        end else begin
            if (i_cmd.start) begin
                r_visited <= '0;
                r_depth   <= '0;
                r_cnt     <= '0;
            end
            if (emit) begin
                r_visited[emit_node[IW-1:0]] <= 1'b1;
                r_cnt                        <= r_cnt + DW'(1);
            end
            if (i_cmd.emit_root) begin
                r_depth <= DW'(1);
            end else if (i_cmd.emit_child) begin
                r_depth <= r_depth + DW'(1);
            end else if (i_cmd.pop) begin
                r_depth <= depth_m1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_n        <= n_use;
            r_src      <= i_node_a;
            r_root     <= i_node_a;
            r_root_par <= i_node_a;
        end
        // restart roots report the search source as parent
        if (i_cmd.next_root) begin
            r_root     <= next_idx;
            r_root_par <= r_src;
        end
        if (i_cmd.row_load) begin
            r_row <= r_adj[top_idx];
        end
        // keep the top of stack in a register; a pop reads the entry below it
        if (i_cmd.emit_root) begin
            r_stack[0] <= r_root;
            r_top      <= r_root;
        end else if (i_cmd.emit_child) begin
            r_stack[r_depth[IW-1:0]] <= found_idx;
            r_top                    <= found_idx;
        end else if (i_cmd.pop) begin
            r_top <= r_stack[depth_m2[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_node <= emit_node;
            r_out_par  <= emit_par;
            r_out_last <= emit_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_visited_node = r_out_node;
    assign o_parent_node  = r_out_par;
    assign o_last         = r_out_last;

    `ASSERT_IMPLY(a_emit_slot_free, i_clk, i_rst_n, emit, out_free)
    `ASSERT_IMPLY(a_emit_unvisited, i_clk, i_rst_n, emit, !r_visited[emit_node[IW-1:0]])
    `ASSERT_IMPLY(a_child_has_parent, i_clk, i_rst_n, i_cmd.emit_child, r_depth != '0)
    `ASSERT_ALWAYS(a_depth_bound, i_clk, i_rst_n, r_depth <= DW'(LIM))

endmodule

`default_nettype wire

// ===== rtl/graph_depth_first_order_top.sv =====
// Depth-first visiting order over an undirected graph of up to 32 nodes.
// Input channel (i_in_valid / o_in_stall): a request with i_cmd = add edge
// sets both matrix bits and gives no result; i_cmd = search
// names the source in i_node_a. A search gives one result per node in use
// (o_visited_node, o_parent_node), preorder with neighbors in ascending
// order, o_last high on the final one; unreached nodes restart the walk
// with the source as parent. A source outside the node count gives nothing.
// Configuration: i_cfg_we writes node_count from i_cfg_data. The user must
// write it only while idle; the block itself does not enforce this.
// Sequence: an accepted search moves to the root state, which loads the root
// into the output register once that is free. Each node takes a row read and
// a neighbor scan when it is pushed, again when it is popped; a root's share
// goes to its load (S_ROOT) and the restart check (S_NEXT). o_in_stall stays
// high until the search is done; the sequencer and the single adjacency row read per scan set the pace.
// Stall: the output register holds its request while i_out_stall is high
// and the walk pauses on its next result; nothing is dropped.
// Reset: synchronous, active low; clears the adjacency matrix, the search
// state and the output valid, and sets node_count to 32.
`default_nettype none

module graph_depth_first_order_top #(
    parameter int MAX_NODES = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [gdfo_pkg::CNT_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_cmd,
    input  logic [gdfo_pkg::NODE_W-1:0] i_node_a,
    input  logic [gdfo_pkg::NODE_W-1:0] i_node_b,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [gdfo_pkg::NODE_W-1:0] o_visited_node,
    output logic [gdfo_pkg::NODE_W-1:0] o_parent_node,
    output logic                        o_last
);
    import gdfo_pkg::*;

    t_ctl_cmd  w_cmd;
    t_ctl_stat w_stat;

    gdfo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    gdfo_dpath #(
        .MAX_NODES (MAX_NODES)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_node_a       (i_node_a),
        .i_node_b       (i_node_b),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_visited_node (o_visited_node),
        .o_parent_node  (o_parent_node),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

// ===== tb/sv/graph_depth_first_order_top_tb.sv =====
`default_nettype none

module graph_depth_first_order_top_tb;

    import gdfo_pkg::*;

    localparam int NODES      = 32;
    localparam int SETTLE     = 4 * NODES + 16;
    localparam int HOLD_LEN   = 400;
    localparam int STUCK_MAX  = 5000;

    typedef struct packed {
        logic              cmd;
        logic [NODE_W-1:0] a;
        logic [NODE_W-1:0] b;
        logic              drain;
    } t_edge_req;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] parent;
        logic              last;
    } t_visit;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [CNT_W-1:0]  cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              cmd = CMD_ADD_EDGE;
    logic [NODE_W-1:0] node_a = '0;
    logic [NODE_W-1:0] node_b = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [NODE_W-1:0] visited_node;
    logic [NODE_W-1:0] parent_node;
    logic              last;

    // predictor state
    logic [NODES-1:0]  adj [NODES];
    logic [NODES-1:0]  seen_mask;
    logic [CNT_W-1:0]  cfg_node_count = NODE_COUNT_RST;

    t_edge_req         req_q[$];
    t_visit            visit_q[$];
    t_edge_req         cur_req;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int rx_hold_req   = 0;
    int rx_hold_seen  = 0;
    int rx_hold_left  = 0;
    int stuck_cycles  = 0;
    int errors        = 0;
    int n_req         = 0;
    int n_search      = 0;
    int n_results     = 0;
    int n_cfg         = 0;

    graph_depth_first_order_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_cmd          (cmd),
        .i_node_a       (node_a),
        .i_node_b       (node_b),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_visited_node (visited_node),
        .o_parent_node  (parent_node),
        .o_last         (last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        for (int r = 0; r < NODES; r++) adj[r] = '0;
        seen_mask = '0;
    end

    // Walk one tree from root; returns the number of visits appended.
    function automatic int walk_tree(input logic [NODE_W-1:0] root,
                                     input logic [NODE_W-1:0] parent, input int n);
        logic [NODE_W-1:0] stack [NODES];
        logic [NODE_W-1:0] top;
        int depth;
        int i;
        int added;
        bit found;
        seen_mask[root] = 1'b1;
        visit_q.push_back('{node: root, parent: parent, last: 1'b0});
        added = 1;
        stack[0] = root;
        depth = 1;
        while (depth > 0) begin
            top = stack[depth-1];
            found = 1'b0;
            for (i = 0; i < n; i++) begin
                if (!seen_mask[i] && adj[top][i]) begin
                    found = 1'b1;
                    break;
                end
            end
            if (found && depth < NODES) begin
                seen_mask[i] = 1'b1;
                visit_q.push_back('{node: NODE_W'(i), parent: top, last: 1'b0});
                added++;
                stack[depth] = NODE_W'(i);
                depth++;
            end else begin
                depth--;
            end
        end
        return added;
    endfunction

    function automatic void predict_visits(input t_edge_req r);
        int n;
        int added;
        n_req++;
        if (r.cmd == CMD_ADD_EDGE) begin
            adj[r.a][r.b] = 1'b1;
            adj[r.b][r.a] = 1'b1;
            return;
        end
        n_search++;
        seen_mask = '0;
        n = (cfg_node_count > NODES) ? NODES : int'(cfg_node_count);
        if (int'(r.a) >= n) return;
        added = walk_tree(r.a, r.a, n);
        for (int v = 0; v < n; v++) begin
            if (!seen_mask[v]) added += walk_tree(NODE_W'(v), r.a, n);
        end
        if (added > 0) visit_q[visit_q.size()-1].last = 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (errors < 40)
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    // request driver
    always @(posedge i_clk) begin
        bit offering;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            offering = in_valid;
            if (in_valid && !in_stall) begin
                predict_visits(cur_req);
                offering = 1'b0;
            end
            if (!offering) begin
                // a drain request waits until every pending visit has come out
                if (req_q.size() != 0 && (!req_q[0].drain || visit_q.size() == 0) &&
                    $urandom_range(99) >= send_idle_pct) begin
                    cur_req = req_q.pop_front();
                    in_valid <= 1'b1;
                    cmd      <= cur_req.cmd;
                    node_a   <= cur_req.a;
                    node_b   <= cur_req.b;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long output hold-off, counted here
    always @(posedge i_clk) begin
        if (rx_hold_left == 0 && rx_hold_req != rx_hold_seen) begin
            rx_hold_left <= HOLD_LEN;
            rx_hold_seen <= rx_hold_req;
        end else if (rx_hold_left > 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_visit want;
        if (i_rst_n && out_valid && !out_stall) begin
            n_results++;
            if (visit_q.size() == 0) begin
                report_mismatch("unexpected visit, node", visited_node, 0);
            end else begin
                want = visit_q.pop_front();
                if (visited_node !== want.node)
                    report_mismatch("visited_node", visited_node, want.node);
                if (parent_node !== want.parent)
                    report_mismatch("parent_node", parent_node, want.parent);
                if (last !== want.last)
                    report_mismatch("last", last, want.last);
            end
        end
        out_stall <= (rx_hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_MAX) begin
            $display("timeout: no request or visit moved for %0d cycles", STUCK_MAX);
            $display("== FAIL ==");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic push_req(input logic c, input int a, input int b, input logic drain);
        req_q.push_back('{cmd: c, a: NODE_W'(a), b: NODE_W'(b), drain: drain});
    endtask

    task automatic wait_idle();
        while (req_q.size() != 0 || in_valid || visit_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_node_count(input int v);
        wait_idle();
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= CNT_W'(v);
        cfg_node_count = CNT_W'(v);
        n_cfg++;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_random(input int count, input int s_pct, input int r_pct,
                              input int ncount);
        int r;
        int k;
        int a;
        int b;
        int n_eff;
        write_node_count(ncount);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        n_eff = (ncount > NODES) ? NODES : ncount;
        for (int j = 0; j < count; j++) begin
            r = $urandom_range(99);
            a = $urandom_range(NODES - 1);
            b = $urandom_range(NODES - 1);
            if (r < 45) begin
                // keep most sources inside the nodes in use
                if (n_eff > 0 && $urandom_range(9) < 8) a = $urandom_range(n_eff - 1);
                push_req(CMD_SEARCH, a, b, $urandom_range(99) < 8);
            end else begin
                k = $urandom_range(9);
                if (k < 6) b = (a + $urandom_range(1, 3)) % NODES;
                else if (k == 9) b = ($urandom_range(1) == 1) ? a : NODES - 1;
                push_req(CMD_ADD_EDGE, a, b, $urandom_range(99) < 8);
            end
        end
        wait_idle();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty graph: every node is its own root under the source
        push_req(CMD_SEARCH, 0, 31, 1'b0);
        push_req(CMD_SEARCH, 31, 0, 1'b1);
        push_req(CMD_ADD_EDGE, 0, 31, 1'b0);
        push_req(CMD_ADD_EDGE, 31, 0, 1'b0);
        push_req(CMD_ADD_EDGE, 5, 5, 1'b0);
        push_req(CMD_ADD_EDGE, 1, 2, 1'b0);
        push_req(CMD_ADD_EDGE, 2, 3, 1'b0);
        push_req(CMD_ADD_EDGE, 3, 4, 1'b0);
        push_req(CMD_ADD_EDGE, 31, 30, 1'b0);
        push_req(CMD_ADD_EDGE, 10, 20, 1'b0);
        push_req(CMD_ADD_EDGE, 2, 9, 1'b0);
        push_req(CMD_SEARCH, 2, 0, 1'b0);
        push_req(CMD_SEARCH, 31, 31, 1'b0);
        push_req(CMD_SEARCH, 5, 0, 1'b0);
        wait_idle();

        // zero nodes: no search gives anything
        write_node_count(0);
        push_req(CMD_SEARCH, 0, 0, 1'b0);
        wait_idle();
        write_node_count(1);
        push_req(CMD_SEARCH, 0, 0, 1'b0);
        push_req(CMD_SEARCH, 1, 0, 1'b0);
        wait_idle();
        // counts above 32 saturate
        write_node_count(63);
        push_req(CMD_SEARCH, 17, 0, 1'b0);
        wait_idle();
        write_node_count(33);
        push_req(CMD_SEARCH, 30, 0, 1'b0);
        wait_idle();
        // edges to nodes beyond the count stay unused
        write_node_count(5);
        push_req(CMD_SEARCH, 4, 0, 1'b0);
        push_req(CMD_SEARCH, 9, 0, 1'b0);
        wait_idle();

        // output held off while the sender keeps pushing
        write_node_count(32);
        rx_hold_req = rx_hold_req + 1;
        for (int j = 0; j < 16; j++) begin
            if (j % 3 == 0) push_req(CMD_SEARCH, $urandom_range(31), 0, 1'b0);
            else push_req(CMD_ADD_EDGE, $urandom_range(31), $urandom_range(31), 1'b0);
        end
        wait_idle();

        run_random(54, 0, 0, 32);
        run_random(54, 75, 0, 9);
        run_random(54, 0, 75, 32);
        run_random(54, 38, 38, 17);
        run_random(54, 0, 0, 2);
        run_random(54, 75, 0, 32);
        run_random(54, 0, 75, 25);
        run_random(54, 38, 38, 63);

        $display("covered %0d requests (%0d searches), %0d visits checked, %0d count writes",
                 n_req, n_search, n_results, n_cfg);
        $display("across node counts 0..63, idle and stall mixes and a long output hold-off");
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
